[hdl/crcdf_pkg.sv]
// Shared types, constants and the CRC step for the CRC-16 response deframer.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package crcdf_pkg;

  // Buffer geometry
  localparam int BUFFER_BYTES = 64;
  localparam int IDX_W        = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int HDR_TRL      = 5;
  localparam int MAX_WORDS    = 29;
  localparam int WORD_W       = $clog2(MAX_WORDS + 1);

  // CRC-16, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;
  localparam logic [7:0]  DEV_ADDR_RST = 8'd1;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  // Request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result codes
  localparam logic       KIND_WORD   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] expected_function;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] reply_word;
    logic [1:0]  status_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Which result the output register takes
  typedef enum logic [1:0] {
    RES_WORD,
    RES_OK,
    RES_CRC,
    RES_TIMEOUT
  } res_sel_e;

  typedef struct packed {
    logic     arm;
    logic     put_byte;
    logic     tick;
    logic     word_clear;
    logic     word_next;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic crc_ok;
    logic timed_out;
    logic words_done;
    logic slot_free;
  } stat_t;

  // One byte folded into the reflected CRC, bit by bit
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hdl/crcdf_cfg.sv]
// Configuration registers behind the APB-style port: device address, timeout.
// Depends on crcdf_pkg.
module crcdf_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crcdf_pkg::ADDR_W-1:0] paddr,
  input  logic [crcdf_pkg::DATA_W-1:0] pwdata,
  output logic [crcdf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output crcdf_pkg::cfg_t             cfg_o
);

  logic [7:0]  dev_addr_q;
  logic [15:0] timeout_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes, decoded on the word index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= crcdf_pkg::DEV_ADDR_RST;
      timeout_q  <= crcdf_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        crcdf_pkg::REG_DEV_ADDR: dev_addr_q <= pwdata[7:0];
        crcdf_pkg::REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      crcdf_pkg::REG_DEV_ADDR: prdata = {{(crcdf_pkg::DATA_W-8){1'b0}}, dev_addr_q};
      crcdf_pkg::REG_TIMEOUT:  prdata = {{(crcdf_pkg::DATA_W-16){1'b0}}, timeout_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.device_address = dev_addr_q;
  assign cfg_o.timeout_ticks  = timeout_q;

endmodule

[hdl/crcdf_dpath.sv]
// Datapath: frame buffer memory, header bytes, CRC, tick counter, word index
// and the output register. Driven by crcdf_ctrl commands; depends on crcdf_pkg.
module crcdf_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crcdf_pkg::in_item_t  in_item_i,
  input  crcdf_pkg::cfg_t      cfg_i,
  input  crcdf_pkg::cmd_t      cmd_i,
  output crcdf_pkg::stat_t     stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output crcdf_pkg::out_item_t out_item_o
);

  localparam int IW = crcdf_pkg::IDX_W;
  localparam int CW = crcdf_pkg::CNT_W;
  localparam int WW = crcdf_pkg::WORD_W;

  logic [7:0] mem [crcdf_pkg::BUFFER_BYTES];

  logic [CW-1:0] count_q;
  logic [15:0]   crc_q;
  logic [15:0]   elapsed_q;
  logic [7:0]    wanted_q;
  logic [7:0]    hdr0_q, hdr1_q, hdr2_q;
  logic [WW-1:0] j_q, j_d;
  logic [7:0]    rd_hi_q, rd_lo_q;
  logic          out_valid_q;
  crcdf_pkg::out_item_t out_item_q;

  logic          full;
  logic          wr_byte;
  logic [15:0]   limit;
  logic [6:0]    half_len;
  logic [WW-1:0] n_words;
  logic [WW:0]   hi_addr, lo_addr;
  logic [8:0]    len_sum;

  assign full    = (count_q == CW'(crcdf_pkg::BUFFER_BYTES));
  assign wr_byte = cmd_i.put_byte && !full;

  // Run state: count, CRC, ticks, wanted code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      crc_q     <= crcdf_pkg::CRC_INIT;
      elapsed_q <= '0;
      wanted_q  <= '0;
    end else if (cmd_i.arm) begin
      count_q   <= '0;
      crc_q     <= crcdf_pkg::CRC_INIT;
      elapsed_q <= '0;
      wanted_q  <= in_item_i.expected_function;
    end else begin
      if (wr_byte) begin
        count_q <= count_q + CW'(1);
        crc_q   <= crcdf_pkg::crc_fold(crc_q, in_item_i.rx_byte);
      end
      if (cmd_i.tick && (elapsed_q != 16'hFFFF)) begin
        elapsed_q <= elapsed_q + 16'd1;
      end
    end
  end

  // Frame buffer and header copies
  always_ff @(posedge clk_i) begin
    if (wr_byte) begin
      mem[count_q[IW-1:0]] <= in_item_i.rx_byte;
      if (count_q == CW'(0)) hdr0_q <= in_item_i.rx_byte;
      if (count_q == CW'(1)) hdr1_q <= in_item_i.rx_byte;
      if (count_q == CW'(2)) hdr2_q <= in_item_i.rx_byte;
    end
  end

  // Word index; read addresses follow its next value so data is ready with it
  always_comb begin
    if (cmd_i.word_clear) begin
      j_d = '0;
    end else if (cmd_i.word_next) begin
      j_d = j_q + WW'(1);
    end else begin
      j_d = j_q;
    end
  end

  assign hi_addr = {j_d, 1'b0} + (WW+1)'(3);
  assign lo_addr = {j_d, 1'b0} + (WW+1)'(4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else begin
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_hi_q <= mem[IW'(hi_addr)];
    rd_lo_q <= mem[IW'(lo_addr)];
  end

  // Completion and timeout checks
  assign len_sum  = {1'b0, hdr2_q} + 9'(crcdf_pkg::HDR_TRL);
  assign half_len = hdr2_q[7:1];
  assign n_words  = (half_len > 7'(crcdf_pkg::MAX_WORDS)) ?
                    WW'(crcdf_pkg::MAX_WORDS) : WW'(half_len);
  assign limit    = (cfg_i.timeout_ticks == 16'd0) ? 16'd1 : cfg_i.timeout_ticks;

  assign stat_o.frame_done = (count_q > CW'(crcdf_pkg::HDR_TRL)) &&
                             (hdr0_q == cfg_i.device_address) &&
                             (hdr1_q == wanted_q) &&
                             (len_sum == 9'(count_q));
  assign stat_o.crc_ok     = (crc_q == 16'd0);
  assign stat_o.timed_out  = (elapsed_q >= limit);
  assign stat_o.words_done = (j_q == n_words);
  assign stat_o.slot_free  = !out_valid_q || !out_stall_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      unique case (cmd_i.res_sel)
        crcdf_pkg::RES_WORD: begin
          out_item_q <= '{crcdf_pkg::KIND_WORD, {rd_hi_q, rd_lo_q},
                          crcdf_pkg::ST_OK, 1'b0};
        end
        crcdf_pkg::RES_OK: begin
          out_item_q <= '{crcdf_pkg::KIND_STATUS, 16'd0, crcdf_pkg::ST_OK, 1'b1};
        end
        crcdf_pkg::RES_CRC: begin
          out_item_q <= '{crcdf_pkg::KIND_STATUS, 16'd0, crcdf_pkg::ST_CRC_ERR, 1'b1};
        end
        crcdf_pkg::RES_TIMEOUT: begin
          out_item_q <= '{crcdf_pkg::KIND_STATUS, 16'd0, crcdf_pkg::ST_TIMEOUT, 1'b1};
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/crcdf_ctrl.sv]
// Controller: reception state machine that sequences the datapath by commands.
// Depends on crcdf_pkg.
module crcdf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       req_type_i,
  output logic             in_stall_o,
  input  crcdf_pkg::stat_t stat_i,
  output crcdf_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ARMED,
    S_EVAL,
    S_WORDS
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q == S_EVAL) || (state_q == S_WORDS);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{arm: 1'b0, put_byte: 1'b0, tick: 1'b0, word_clear: 1'b0,
                word_next: 1'b0, load_out: 1'b0, res_sel: crcdf_pkg::RES_WORD};
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == crcdf_pkg::REQ_START)) begin
          cmd_o.arm = 1'b1;
          state_d   = S_ARMED;
        end
      end
      S_ARMED: begin
        if (accept) begin
          unique case (req_type_i)
            crcdf_pkg::REQ_START: cmd_o.arm = 1'b1;
            crcdf_pkg::REQ_BYTE: begin
              cmd_o.put_byte = 1'b1;
              state_d        = S_EVAL;
            end
            crcdf_pkg::REQ_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = S_EVAL;
            end
            default: ;
          endcase
        end
      end
      // Look at the updated counters in the cycle after a byte or tick
      S_EVAL: begin
        priority if (stat_i.timed_out) begin
          if (stat_i.slot_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.res_sel  = crcdf_pkg::RES_TIMEOUT;
            state_d        = S_IDLE;
          end
        end else if (stat_i.frame_done && !stat_i.crc_ok) begin
          if (stat_i.slot_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.res_sel  = crcdf_pkg::RES_CRC;
            state_d        = S_IDLE;
          end
        end else if (stat_i.frame_done) begin
          cmd_o.word_clear = 1'b1;
          state_d          = S_WORDS;
        end else begin
          state_d = S_ARMED;
        end
      end
      // One payload word per free output slot, then status ok
      S_WORDS: begin
        if (stat_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.words_done) begin
            cmd_o.res_sel = crcdf_pkg::RES_OK;
            state_d       = S_IDLE;
          end else begin
            cmd_o.res_sel   = crcdf_pkg::RES_WORD;
            cmd_o.word_next = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/crc16_response_deframer.sv]
// CRC-16 reply deframer, top level.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries start, byte and
// tick items; an item moves at a clock edge with valid high and stall low.
// A start arms reception and sets the function code the reply must carry.
// Each byte is stored in a 64-entry buffer memory and folded into the CRC.
// A byte or tick is accepted and then checked in the controller's check state,
// during which in_stall_o is high. Output channel (out_valid_o / out_stall_i /
// out_item_o) is fed from one output register. A good frame gives one item per
// cycle while out_stall_i is low: floor(length/2) payload words read from the
// buffer over two read ports, then status ok; the word state loads each word
// from the read registers into the output register. Errors give a single status
// item (crc error or timeout), loaded from the check state once the output slot is free.
// While out_stall_i is high the output register holds; a word run pauses and
// the input stays stalled, but after a final status the block takes new items
// while the status waits.
// Reset clears the run state and returns to idle; configuration registers go
// to address 1 and 1000 ticks. Bytes and ticks are ignored while idle.
// Registers sit at byte addresses 0 (device address) and 4 (timeout ticks).
module crc16_response_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  crcdf_pkg::in_item_t          in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output crcdf_pkg::out_item_t         out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crcdf_pkg::ADDR_W-1:0] paddr,
  input  logic [crcdf_pkg::DATA_W-1:0] pwdata,
  output logic [crcdf_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  crcdf_pkg::cfg_t  cfg;
  crcdf_pkg::cmd_t  cmd;
  crcdf_pkg::stat_t stat;

  crcdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crcdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_item_i.req_type),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crcdf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/crcdf_checker.sv]
// Port-level assertions for the CRC-16 reply deframer, bound to its top level.
// Depends on crcdf_pkg and crc16_response_deframer.
module crcdf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input crcdf_pkg::in_item_t          in_item_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input crcdf_pkg::out_item_t         out_item_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [crcdf_pkg::ADDR_W-1:0] paddr,
  input logic [crcdf_pkg::DATA_W-1:0] pwdata,
  input logic [crcdf_pkg::DATA_W-1:0] prdata,
  input logic                         pready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // Status items end a run and carry no word
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == crcdf_pkg::KIND_STATUS) |->
    out_item_o.last && (out_item_o.reply_word == 16'd0))
    else $error("status item without last or with nonzero word");

  // Payload words never end a run and carry status ok
  a_word_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == crcdf_pkg::KIND_WORD) |->
    !out_item_o.last && (out_item_o.status_code == crcdf_pkg::ST_OK))
    else $error("payload word flagged last or with a status");

  // While payload words are shown, input stays stalled
  a_word_stalls_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == crcdf_pkg::KIND_WORD) |-> in_stall_o)
    else $error("input accepted during a word run");

endmodule

bind crc16_response_deframer crcdf_checker u_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for crc16_response_deframer: a table of directed items,
// then random reply frames, each checked against an in-bench deframing predictor.
// Depends on crcdf_pkg (types, codes, buffer geometry) and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import crcdf_pkg::*;

  localparam int         CLK_HALF      = 10;
  localparam int         RESET_CYCLES  = 6;
  localparam int         LIMIT_CYCLES  = 400000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         END_WAIT      = 20000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         PHASE_ITEMS   = 32;
  localparam int         NUM_PHASES    = 6;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  // How a directed row fills its data byte
  typedef enum logic [1:0] {CRC_NONE, CRC_GOOD, CRC_BAD} crc_fill_e;
  // Flavors of a generated reply frame
  typedef enum logic [1:0] {FR_GOOD, FR_CORRUPT, FR_BAD_HEADER} frame_e;

  typedef struct {
    in_item_t  stim;
    crc_fill_e fill;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predictor copy of the registers and the run state
  logic [7:0]  cfg_dev;
  logic [15:0] cfg_timeout;
  logic [7:0]  rx_buf [BUFFER_BYTES];
  int          rx_count;
  logic [15:0] rx_crc;
  bit          rx_armed;
  logic [7:0]  want_func;
  int          tick_count;

  out_item_t   reply_q [$];
  plan_row_t   plan [$];
  int          err_count;
  int          fed_count;
  int          hold_cycles;
  int          cycles;
  bit          steady;

  crc16_response_deframer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ERROR %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic in_item_t mk_in(input logic [1:0] req, input logic [7:0] func,
                                     input logic [7:0] b);
    in_item_t it;
    it.req_type          = req;
    it.expected_function = func;
    it.rx_byte           = b;
    return it;
  endfunction

  function automatic out_item_t mk_out(input logic kind, input logic [15:0] word,
                                       input logic [1:0] st, input logic fin);
    out_item_t r;
    r.result_kind = kind;
    r.reply_word  = word;
    r.status_code = st;
    r.last        = fin;
    return r;
  endfunction

  // Reflected CRC-16, one data bit at a time, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[15:1]};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Predictor: advance the run state by one accepted item, queue its results
  task automatic deframe_step(input in_item_t it);
    int limit;
    int nwords;
    case (it.req_type)
      REQ_START: begin
        rx_count   = 0;
        rx_crc     = CRC_INIT;
        tick_count = 0;
        want_func  = it.expected_function;
        rx_armed   = 1'b1;
      end
      REQ_TICK: if (rx_armed) begin
        limit = (cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout);
        if (tick_count < 16'hFFFF) tick_count++;
        if (tick_count >= limit) begin
          rx_armed = 1'b0;
          reply_q.push_back(mk_out(KIND_STATUS, 16'h0000, ST_TIMEOUT, 1'b1));
        end
      end
      REQ_BYTE: if (rx_armed && rx_count < BUFFER_BYTES) begin
        rx_buf[rx_count] = it.rx_byte;
        rx_count++;
        rx_crc = crc16_step(rx_crc, it.rx_byte);
        if (rx_count > HDR_TRL && rx_buf[0] == cfg_dev && rx_buf[1] == want_func &&
            int'(rx_buf[2]) + HDR_TRL == rx_count) begin
          rx_armed = 1'b0;
          if (rx_crc != 16'h0000) begin
            reply_q.push_back(mk_out(KIND_STATUS, 16'h0000, ST_CRC_ERR, 1'b1));
          end else begin
            nwords = int'(rx_buf[2]) / 2;
            if (nwords > MAX_WORDS) nwords = MAX_WORDS;
            for (int j = 0; j < nwords; j++) begin
              reply_q.push_back(mk_out(KIND_WORD, {rx_buf[3 + 2 * j], rx_buf[4 + 2 * j]},
                                       ST_OK, 1'b0));
            end
            reply_q.push_back(mk_out(KIND_STATUS, 16'h0000, ST_OK, 1'b1));
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one item and hold it until accepted; valid stays high afterwards
  task automatic send(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (it.req_type == REQ_START || rx_armed) fed_count++;
    deframe_step(it);
  endtask

  // Reply frame: address, function, length, data, CRC low, CRC high
  task automatic send_frame(input frame_e kind, input int len, input int ticks);
    logic [7:0] func;
    logic [7:0] b;
    logic [7:0] mask;
    int         total;
    int         flip_at;
    total   = len + HDR_TRL;
    func    = $urandom;
    mask    = 8'h01 << $urandom_range(0, 7);
    flip_at = -1;
    if (kind == FR_CORRUPT) flip_at = $urandom_range(3, total - 1);
    if (kind == FR_BAD_HEADER) flip_at = $urandom_range(0, 1);
    send(mk_in(REQ_START, func, $urandom));
    for (int i = 0; i < total; i++) begin
      if (ticks > 0 && $urandom_range(0, 3) == 0) begin
        send(mk_in(REQ_TICK, $urandom, $urandom));
        ticks--;
      end
      if (i == 0) b = cfg_dev;
      else if (i == 1) b = func;
      else if (i == 2) b = len[7:0];
      else if (i < total - 2) b = $urandom;
      else b = rx_crc[7:0];
      if (i == flip_at) b = b ^ mask;
      send(mk_in(REQ_BYTE, $urandom, b));
    end
  endtask

  // Start, bytes that never frame (wrong address), then ticks toward a timeout
  task automatic stray_run(input int nbytes);
    int n;
    send(mk_in(REQ_START, $urandom, $urandom));
    for (int i = 0; i < nbytes; i++) begin
      send(mk_in(REQ_BYTE, $urandom, (i == 0) ? ~cfg_dev : 8'($urandom)));
    end
    n = (cfg_timeout <= 16'd40) ? int'(cfg_timeout) : $urandom_range(1, 6);
    repeat (n) send(mk_in(REQ_TICK, $urandom, $urandom));
  endtask

  task automatic random_txn();
    int r;
    int len;
    int ticks;
    r      = $urandom_range(0, 99);
    steady = ($urandom_range(0, 3) == 0);
    len    = ($urandom_range(0, 6) == 0) ? $urandom_range(9, BUFFER_BYTES - HDR_TRL)
                                         : $urandom_range(1, 8);
    ticks  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    if (r < 55) send_frame(FR_GOOD, len, ticks);
    else if (r < 70) send_frame(FR_CORRUPT, len, ticks);
    else if (r < 78) send_frame(FR_BAD_HEADER, len, ticks);
    else if (r < 90) stray_run($urandom_range(0, 6));
    else repeat ($urandom_range(1, 4)) send(mk_in($urandom_range(0, 3), $urandom, $urandom));
  endtask

  // Let every expected result come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup, access until pready, then bus back to idle
  task automatic apb_xfer(input bit wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
    if (idx == REG_DEV_ADDR) begin
      if (rd[7:0] !== cfg_dev) report("device_address readback", rd[7:0], cfg_dev);
    end else begin
      if (rd[15:0] !== cfg_timeout) report("timeout_ticks readback", rd[15:0], cfg_timeout);
    end
  endtask

  task automatic set_reg(input logic idx, input logic [15:0] value);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b1, {idx, 2'b00}, {16'h0000, value}, rd);
    if (idx == REG_DEV_ADDR) cfg_dev = value[7:0];
    else cfg_timeout = value;
    check_reg(idx);
  endtask

  task automatic row(input logic [1:0] req, input logic [7:0] func, input logic [7:0] b,
                     input crc_fill_e fill = CRC_NONE, input bit typed = 1'b0,
                     input out_item_t want = '0);
    plan_row_t p;
    p.stim  = mk_in(req, func, b);
    p.fill  = fill;
    p.typed = typed;
    p.want  = want;
    plan.push_back(p);
  endtask

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        report("result with nothing expected", out_item, '0);
      end else begin
        exp_r = reply_q.pop_front();
        if (out_item.result_kind !== exp_r.result_kind)
          report("result_kind", out_item.result_kind, exp_r.result_kind);
        if (out_item.reply_word !== exp_r.reply_word)
          report("reply_word", out_item.reply_word, exp_r.reply_word);
        if (out_item.status_code !== exp_r.status_code)
          report("status_code", out_item.status_code, exp_r.status_code);
        if (out_item.last !== exp_r.last)
          report("last", out_item.last, exp_r.last);
      end
    end
  end

  // Receiver stall: flowing, short stalls, idle-free stretches, long stalls,
  // and one long hold on request so the block backs up into its input
  initial begin
    int r;
    int n;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 4);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 93) begin
          out_stall <= 1'b0;
          n = $urandom_range(20, 60);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(8, 40);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // Run guard
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    in_item_t    stim;
    logic [7:0]  dev;
    logic [15:0] tmo;
    int          target;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_dev     = DEV_ADDR_RST;
    cfg_timeout = TIMEOUT_RST;
    rx_count    = 0;
    rx_crc      = CRC_INIT;
    rx_armed    = 1'b0;
    want_func   = 8'h00;
    tick_count  = 0;
    err_count   = 0;
    fed_count   = 0;
    hold_cycles = 0;
    steady      = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reg(REG_DEV_ADDR);
    check_reg(REG_TIMEOUT);

    // Directed table, reset configuration (address 1, 1000 ticks)
    row(REQ_BYTE,   8'h00, 8'hFF);                      // byte while idle
    row(REQ_TICK,   8'hFF, 8'h00);                      // tick while idle
    row(REQ_UNUSED, 8'hFF, 8'hFF);                      // unused request
    row(REQ_START,  8'h00, 8'h00);                      // function code 0x00
    row(REQ_BYTE,   8'h00, 8'h01);
    row(REQ_BYTE,   8'h00, 8'h00);
    row(REQ_BYTE,   8'h00, 8'h04);                      // length 4
    row(REQ_BYTE,   8'h00, 8'h00);
    row(REQ_BYTE,   8'h00, 8'hFF);
    row(REQ_BYTE,   8'h00, 8'h80);
    row(REQ_BYTE,   8'h00, 8'h01);
    row(REQ_BYTE,   8'h00, 8'h00, CRC_GOOD);
    row(REQ_BYTE,   8'h00, 8'h00, CRC_GOOD, 1'b1, mk_out(KIND_STATUS, 16'h0000, ST_OK, 1'b1));
    row(REQ_START,  8'hFF, 8'h00);                      // function code 0xFF
    row(REQ_TICK,   8'h00, 8'h00);                      // tick while armed, far from limit
    row(REQ_BYTE,   8'h00, 8'h01);
    row(REQ_START,  8'hFF, 8'h00);                      // restart drops partial frame
    row(REQ_BYTE,   8'h00, 8'h01);
    row(REQ_BYTE,   8'h00, 8'hFF);
    row(REQ_BYTE,   8'h00, 8'h01);                      // odd length, no word
    row(REQ_BYTE,   8'h00, 8'hAA);
    row(REQ_BYTE,   8'h00, 8'h00, CRC_GOOD);
    row(REQ_BYTE,   8'h00, 8'h00, CRC_BAD, 1'b1,
        mk_out(KIND_STATUS, 16'h0000, ST_CRC_ERR, 1'b1));

    foreach (plan[i]) begin
      stim = plan[i].stim;
      if (plan[i].fill != CRC_NONE)
        stim.rx_byte = rx_crc[7:0] ^ {7'd0, plan[i].fill == CRC_BAD};
      send(stim);
      if (plan[i].typed) begin
        if (reply_q.size() != 0) void'(reply_q.pop_back());
        reply_q.push_back(plan[i].want);
      end
    end
    drain();

    // Random phases, one register setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin dev = 8'h00; tmo = 16'hFFFF; end
        1: begin dev = 8'hFF; tmo = 16'd1; end
        2: begin dev = $urandom; tmo = $urandom_range(2, 12); end
        3: begin dev = $urandom; tmo = 16'd7; end
        4: begin dev = $urandom; tmo = $urandom_range(13, 40); end
        default: begin dev = DEV_ADDR_RST; tmo = $urandom_range(2, 30); end
      endcase
      set_reg(REG_DEV_ADDR, {8'h00, dev});
      set_reg(REG_TIMEOUT, tmo);
      target = fed_count + PHASE_ITEMS;

      // full buffer, longest payload
      if (ph == 0) send_frame(FR_GOOD, BUFFER_BYTES - HDR_TRL, 0);
      // bytes past the end of the buffer, then timeout
      if (ph == 2) stray_run(BUFFER_BYTES + 4);
      // back-to-back frames against a long receiver hold
      if (ph == 3) begin
        hold_cycles = HOLD_CYCLES;
        steady      = 1'b1;
        repeat (6) send_frame(FR_GOOD, $urandom_range(4, 16), 0);
      end

      while (fed_count < target) random_txn();
      steady = 1'b0;
      // closing frame leaves the block idle for the next register writes
      send_frame(FR_GOOD, $urandom_range(1, 8), 0);
      if (ph != NUM_PHASES - 1) drain();
    end

    in_valid <= 1'b0;
    for (int w = 0; w < END_WAIT && reply_q.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reply_q.size() != 0) report("results never delivered", reply_q.size(), 0);

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/crcdf_pkg.sv
hdl/crcdf_cfg.sv
hdl/crcdf_dpath.sv
hdl/crcdf_ctrl.sv
hdl/crc16_response_deframer.sv
hdl/crcdf_checker.sv
tb/testbench.sv
